>>> hdl/mtx_pkg.sv
// Package for the mutex table unit: request, status and control-state types.
// No dependencies; imported by the top level and the port checker.
package mtx_pkg;

  typedef enum logic [1:0] {
    FN_CREATE  = 2'd0,
    FN_ENTER   = 2'd1,
    FN_EXIT    = 2'd2,
    FN_DESTROY = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_WAIT      = 3'd1,
    ST_NOT_OWNER = 3'd2,
    ST_INVALID   = 3'd3,
    ST_BUSY      = 3'd4,
    ST_FULL      = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  // One captured request.
  typedef struct packed {
    func_t      func;
    logic [4:0] mutex_id;
    logic [7:0] task_id;
    logic       mutex_type;
  } req_t;

  localparam int ID_W     = 5;
  localparam int TASK_W   = 8;
  localparam int STATUS_W = 3;

endpackage

>>> hdl/mtx_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; used for the per-slot state of the mutex table unit.
module mtx_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/mutex_table_unit.sv
// Mutex table unit: slot table serving create, enter, exit and destroy requests.
// Depends on mtx_pkg (types, codes) and mtx_ram (per-slot strict/lock/owner store).
//
// Usage:
//   Input channel (in_*): one request per accepted item. in_tuser carries the
//   function code (create, enter, exit, destroy); in_tdata carries the slot,
//   the calling task and the mutex type for create.
//   Output channel (out_*): exactly one result per request, in request order:
//   status, the slot taken by a successful create and the wake-waiters flag.
// Sequencing:
//   A request is accepted in the idle cycle that also issues the slot read;
//   the next cycle the read data returns, and when the output register is
//   free the slot is updated and the result is loaded into it, which raises
//   out_tvalid. A new request is taken only in the idle state, so the slot
//   read-modify-write finishes before the next request is accepted.
// Stalls:
//   The output register holds a result until it is taken. A new request is
//   still accepted meanwhile; its update then waits until the output is free.
// Reset:
//   Clears the slot-in-use bitmap, the upper-slot fill count and the channel
//   state; in_tready stays low while reset is held. The slot memory is not
//   cleared: a slot is read only while in use, and create always writes it
//   first. Slots above the 32 addressable ones fill in order (fill count).
module mutex_table_unit
  import mtx_pkg::*;
#(
  parameter int MUTEX_SLOTS  = 32,
  parameter int TASK_ID_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [4:0] mutex_id, [12:5] task_id, [13] mutex_type
  input  logic [1:0]  in_tuser,   // [1:0] func
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [2:0] status, [7:3] new_id, [8] wake_waiters
);

  // Slots reachable by a handle live in the bitmap and memory; the rest are
  // tracked by a fill count.
  localparam int LO_SLOTS = (MUTEX_SLOTS < 32) ? MUTEX_SLOTS : 32;
  localparam int HI_SLOTS = MUTEX_SLOTS - LO_SLOTS;
  localparam int ADDR_W   = $clog2(LO_SLOTS);
  localparam int HI_W     = $clog2(HI_SLOTS + 2);
  localparam int ENT_W    = TASK_ID_BITS + 2;
  localparam logic [TASK_W-1:0] TASK_MASK =
    (TASK_ID_BITS >= TASK_W) ? {TASK_W{1'b1}} : TASK_W'((1 << TASK_ID_BITS) - 1);

  state_t               state_r, state_nxt;
  req_t                 req_r, req_nxt, req_in;
  logic [LO_SLOTS-1:0]  in_use_r, in_use_nxt;
  logic [HI_W-1:0]      hi_cnt_r, hi_cnt_nxt;
  logic                 out_tvalid_r, out_tvalid_nxt;
  logic [15:0]          out_tdata_r, out_tdata_nxt;

  logic                 in_fire, exec_fire;
  logic [ADDR_W-1:0]    ram_raddr, ram_waddr, slot_addr;
  logic [ENT_W-1:0]     ram_rdata, ram_wdata;
  logic                 ram_we;

  logic                 free_found;
  logic [ADDR_W-1:0]    free_idx;
  logic                 id_ok;
  logic                 ent_strict, ent_locked, owner_match;
  logic [TASK_ID_BITS-1:0] ent_owner, req_task;

  status_t              status;
  logic [ID_W-1:0]      new_id;
  logic                 wake;

  assign req_in.func       = func_t'(in_tuser);
  assign req_in.mutex_id   = in_tdata[4:0];
  assign req_in.task_id    = in_tdata[12:5];
  assign req_in.mutex_type = in_tdata[13];

  assign in_tready  = rst_n && (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  // Finish only when the output register can take the result.
  assign exec_fire  = (state_r == S_EXEC) && (!out_tvalid_r || out_tready);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // Read the incoming slot while idle; keep re-reading it while a result stalls.
  assign ram_raddr = (state_r == S_IDLE) ? ADDR_W'(req_in.mutex_id)
                                         : ADDR_W'(req_r.mutex_id);
  assign slot_addr = ADDR_W'(req_r.mutex_id);

  mtx_ram #(
    .WIDTH (ENT_W),
    .DEPTH (LO_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Lowest free addressable slot.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = LO_SLOTS - 1; i >= 0; i--) begin
      if (!in_use_r[i]) begin
        free_found = 1'b1;
        free_idx   = ADDR_W'(i);
      end
    end
  end

  assign ent_strict  = ram_rdata[ENT_W-1];
  assign ent_locked  = ram_rdata[ENT_W-2];
  assign ent_owner   = ram_rdata[TASK_ID_BITS-1:0];
  assign req_task    = TASK_ID_BITS'(req_r.task_id & TASK_MASK);
  assign owner_match = (ent_owner == req_task);
  assign id_ok       = (32'(req_r.mutex_id) < 32'(MUTEX_SLOTS)) && in_use_r[slot_addr];

  // Decide the result and the slot update.
  always_comb begin
    status     = ST_DONE;
    new_id     = '0;
    wake       = 1'b0;
    in_use_nxt = in_use_r;
    hi_cnt_nxt = hi_cnt_r;
    ram_we     = 1'b0;
    ram_waddr  = slot_addr;
    ram_wdata  = ram_rdata;
    unique case (req_r.func)
      FN_CREATE: begin
        if (free_found) begin
          in_use_nxt[free_idx] = 1'b1;
          ram_we    = 1'b1;
          ram_waddr = free_idx;
          ram_wdata = {req_r.mutex_type, 1'b0, {TASK_ID_BITS{1'b0}}};
          new_id    = ID_W'(free_idx);
        end else if (hi_cnt_r < HI_W'(HI_SLOTS)) begin
          hi_cnt_nxt = hi_cnt_r + 1'b1;
          new_id     = ID_W'(hi_cnt_r);
        end else begin
          status = ST_FULL;
        end
      end
      FN_ENTER: begin
        if (!id_ok) begin
          status = ST_INVALID;
        end else if (!ent_locked) begin
          ram_we    = 1'b1;
          ram_wdata = {ent_strict, 1'b1, ent_strict ? req_task : {TASK_ID_BITS{1'b0}}};
        end else if (!(ent_strict && owner_match)) begin
          status = ST_WAIT;
        end
      end
      FN_EXIT: begin
        if (!id_ok) begin
          status = ST_INVALID;
        end else if (ent_strict && !(ent_locked && owner_match)) begin
          status = ST_NOT_OWNER;
        end else begin
          ram_we    = 1'b1;
          ram_wdata = {ent_strict, 1'b0, {TASK_ID_BITS{1'b0}}};
          wake      = 1'b1;
        end
      end
      FN_DESTROY: begin
        if (!id_ok) begin
          status = ST_INVALID;
        end else if (ent_locked) begin
          status = ST_BUSY;
        end else begin
          // drop the slot; create rewrites its memory entry
          in_use_nxt[slot_addr] = 1'b0;
        end
      end
      default: begin
        status = ST_INVALID;
      end
    endcase
    if (!exec_fire) begin
      ram_we     = 1'b0;
      in_use_nxt = in_use_r;
      hi_cnt_nxt = hi_cnt_r;
    end
  end

  // Sequencing and output register.
  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          req_nxt   = req_in;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_fire) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {7'b0, wake, new_id, status};
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      in_use_r     <= '0;
      hi_cnt_r     <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      in_use_r     <= in_use_nxt;
      hi_cnt_r     <= hi_cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

endmodule

>>> hdl/mtx_chk.sv
// Port checker for the mutex table unit, attached by bind.
// Depends on mtx_pkg for the status codes.
module mtx_chk
  import mtx_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // One request at a time: the channel closes right after an accept.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while another is in work");

  // Each request accepted while the output is free yields a result via the execute state.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (!out_tvalid || out_tready) |=> ##1 out_tvalid)
    else $error("result missing after request");

  // A result with a status other than done has slot, wake flag and padding zero and a defined status code.
  a_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[2:0] != 3'(ST_DONE)) |->
      out_tdata[15:3] == 13'd0 && out_tdata[2:0] != 3'd6 && out_tdata[2:0] != 3'd7)
    else $error("bad result fields");

  // Reset empties the output.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind mutex_table_unit mtx_chk u_mtx_chk (.*);

>>> sim/tb_mutex_table_unit.sv
// Testbench for mutex_table_unit: directed and random requests with a predictor
// of the slot table. Depends on mtx_pkg and the mutex_table_unit RTL only.
`timescale 1ns / 1ps

module tb_mutex_table_unit;
  import mtx_pkg::*;

  localparam int SLOTS          = 32;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PHASE_ITEMS    = 110;

  // One request waiting to go out, with its lead-in gap and drain flag.
  typedef struct {
    func_t       fn;
    logic [4:0]  id;
    logic [7:0]  tid;
    logic        mt;
    bit          drain;
    int unsigned gap;
  } request_t;

  typedef struct {
    status_t    status;
    logic [4:0] new_id;
    logic       wake;
  } result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;   // [4:0] mutex_id, [12:5] task_id, [13] mutex_type
  logic [1:0]  in_tuser   = '0;   // [1:0] func
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;         // [2:0] status, [7:3] new_id, [8] wake_waiters

  request_t    request_q[$];
  result_t     pending_results[$];
  int unsigned requests_total;
  int unsigned requests_accepted;
  int unsigned errors;
  int unsigned idle_cycles;

  // Stimulus shaping: tx_quiet and drain_next set by the filling code, rx_quiet by the monitor.
  bit          tx_quiet;
  bit          drain_next;
  bit          rx_quiet;

  // Shadow of the slot table.
  bit          slot_used   [SLOTS];
  bit          slot_strict [SLOTS];
  bit          slot_locked [SLOTS];
  logic [7:0]  slot_owner  [SLOTS];

  mutex_table_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Apply one accepted request to the shadow table and return its outcome.
  function automatic result_t resolve_request(func_t fn, logic [4:0] id, logic [7:0] tid,
                                              logic mt);
    result_t r;
    bit      found;
    r.status = ST_DONE;
    r.new_id = '0;
    r.wake   = 1'b0;
    found    = 1'b0;
    if (fn == FN_CREATE) begin
      // Lowest free slot wins; none free means the table is full.
      r.status = ST_FULL;
      for (int i = 0; i < SLOTS; i++) begin
        if (!found && !slot_used[i]) begin
          found          = 1'b1;
          slot_used[i]   = 1'b1;
          slot_strict[i] = mt;
          slot_locked[i] = 1'b0;
          slot_owner[i]  = '0;
          r.new_id       = i[4:0];
          r.status       = ST_DONE;
        end
      end
    end else if (!slot_used[id]) begin
      r.status = ST_INVALID;
    end else if (fn == FN_ENTER) begin
      if (!slot_locked[id]) begin
        slot_locked[id] = 1'b1;
        slot_owner[id]  = slot_strict[id] ? tid : 8'd0;
      end else if (!(slot_strict[id] && slot_owner[id] == tid)) begin
        // Owner re-entry is granted silently; everyone else waits.
        r.status = ST_WAIT;
      end
    end else if (fn == FN_EXIT) begin
      if (slot_strict[id] && !(slot_locked[id] && slot_owner[id] == tid)) begin
        r.status = ST_NOT_OWNER;
      end else begin
        slot_locked[id] = 1'b0;
        slot_owner[id]  = '0;
        r.wake          = 1'b1;
      end
    end else begin
      if (slot_locked[id]) begin
        r.status = ST_BUSY;
      end else begin
        slot_used[id]   = 1'b0;
        slot_strict[id] = 1'b0;
        slot_owner[id]  = '0;
      end
    end
    return r;
  endfunction

  task automatic push_request(func_t fn, logic [4:0] id, logic [7:0] tid, logic mt);
    request_t q;
    q.fn    = fn;
    q.id    = id;
    q.tid   = tid;
    q.mt    = mt;
    q.drain = drain_next;
    q.gap   = tx_quiet ? 0 : $urandom_range(0, 16);
    drain_next = 1'b0;
    request_q.push_back(q);
    requests_total++;
  endtask

  // Driver: present queued requests, honoring each one's gap and drain flag.
  int unsigned gap_count;
  always @(posedge clk) begin
    logic nxt_valid;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_count = 0;
    end else begin
      nxt_valid = in_tvalid;
      if (in_tvalid && in_tready) begin
        pending_results.push_back(resolve_request(func_t'(in_tuser), in_tdata[4:0],
                                                  in_tdata[12:5], in_tdata[13]));
        requests_accepted++;
        nxt_valid = 1'b0;
        gap_count = 0;
      end
      if (!nxt_valid && request_q.size() != 0) begin
        if (request_q[0].drain && pending_results.size() != 0) begin
          // hold until every outstanding result has come back
        end else if (gap_count < request_q[0].gap) begin
          gap_count++;
        end else begin
          in_tdata  <= {2'b00, request_q[0].mt, request_q[0].tid, request_q[0].id};
          in_tuser  <= request_q[0].fn;
          nxt_valid = 1'b1;
          void'(request_q.pop_front());
        end
      end
      in_tvalid <= nxt_valid;
    end
  end

  // Monitor: take results with random stalls and check them in order.
  int unsigned stall_left;
  always @(posedge clk) begin
    logic    nxt_ready;
    result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
    end else begin
      nxt_ready = out_tready;
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: result with none expected, expected none, actual %h",
                   $time, out_tdata);
        end else begin
          want = pending_results.pop_front();
          if (out_tdata[2:0] !== want.status) begin
            errors++;
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, out_tdata[2:0]);
          end
          if (out_tdata[7:3] !== want.new_id) begin
            errors++;
            $display("%0t: new_id mismatch, expected %0d, actual %0d",
                     $time, want.new_id, out_tdata[7:3]);
          end
          if (out_tdata[8] !== want.wake) begin
            errors++;
            $display("%0t: wake_waiters mismatch, expected %0b, actual %0b",
                     $time, want.wake, out_tdata[8]);
          end
        end
        if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
        stall_left = rx_quiet ? 0 : $urandom_range(0, 16);
        nxt_ready  = 1'b0;
      end
      if (!nxt_ready) begin
        if (stall_left > 0) stall_left--;
        else nxt_ready = 1'b1;
      end
      out_tready <= nxt_ready;
    end
  end

  // Watchdog: a hang shows up as a long stretch with no handshake.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned r;
    int unsigned id_hi;
    int unsigned tid_hi;
    int unsigned w_create;
    int unsigned w_session;
    int unsigned w_destroy;
    logic [4:0]  id;
    logic [7:0]  tid;
    logic [7:0]  tid2;

    // Directed: unused handles, normal and strict locking, busy destroy, task zero.
    push_request(FN_ENTER,   5'd0,  8'd1,   1'b0);  // slot not in use
    push_request(FN_EXIT,    5'd31, 8'd255, 1'b1);
    push_request(FN_DESTROY, 5'd31, 8'd255, 1'b0);
    push_request(FN_CREATE,  5'd31, 8'd0,   1'b0);  // normal -> slot 0
    push_request(FN_CREATE,  5'd0,  8'd255, 1'b1);  // strict -> slot 1
    push_request(FN_ENTER,   5'd0,  8'd1,   1'b0);
    push_request(FN_ENTER,   5'd0,  8'd2,   1'b0);  // normal locked: wait
    push_request(FN_DESTROY, 5'd0,  8'd1,   1'b0);  // locked: busy
    push_request(FN_EXIT,    5'd0,  8'd9,   1'b0);  // any task may release
    push_request(FN_EXIT,    5'd0,  8'd9,   1'b0);  // normal exit while unlocked
    push_request(FN_EXIT,    5'd1,  8'd255, 1'b0);  // strict exit while unlocked
    push_request(FN_ENTER,   5'd1,  8'd255, 1'b0);
    push_request(FN_ENTER,   5'd1,  8'd255, 1'b0);  // owner re-entry
    push_request(FN_ENTER,   5'd1,  8'd1,   1'b0);  // other task waits
    push_request(FN_EXIT,    5'd1,  8'd1,   1'b0);  // exit by non-owner
    push_request(FN_DESTROY, 5'd1,  8'd1,   1'b0);
    push_request(FN_EXIT,    5'd1,  8'd255, 1'b0);
    push_request(FN_DESTROY, 5'd1,  8'd255, 1'b0);
    push_request(FN_ENTER,   5'd1,  8'd3,   1'b0);  // destroyed handle
    push_request(FN_CREATE,  5'd7,  8'd0,   1'b1);  // strict again in slot 1
    push_request(FN_ENTER,   5'd1,  8'd0,   1'b0);  // task zero owns it
    push_request(FN_ENTER,   5'd1,  8'd0,   1'b0);
    push_request(FN_EXIT,    5'd1,  8'd0,   1'b0);
    push_request(FN_DESTROY, 5'd0,  8'd0,   1'b0);

    // Fill the table past its end so create reports full and slot 31 is taken.
    drain_next = 1'b1;
    for (int i = 0; i < 34; i++)
      push_request(FN_CREATE, 5'($urandom), 8'($urandom), 1'($urandom));

    // Random phases: mostly enter/exit sessions (none in phase 4) on random handles, some noise.
    for (int p = 0; p < 6; p++) begin
      drain_next = (p % 2 == 0);
      tx_quiet   = (p == 1 || p == 4);
      case (p)
        0:       begin id_hi = 7;  tid_hi = 4;   w_create = 10; w_session = 60; w_destroy = 10; end
        1:       begin id_hi = 31; tid_hi = 255; w_create = 5;  w_session = 70; w_destroy = 5;  end
        2:       begin id_hi = 15; tid_hi = 3;   w_create = 5;  w_session = 40; w_destroy = 40; end
        3:       begin id_hi = 31; tid_hi = 8;   w_create = 40; w_session = 40; w_destroy = 5;  end
        4:       begin id_hi = 31; tid_hi = 255; w_create = 25; w_session = 0;  w_destroy = 25; end
        default: begin id_hi = 3;  tid_hi = 2;   w_create = 15; w_session = 55; w_destroy = 15; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; ) begin
        r    = $urandom_range(0, 99);
        id   = 5'($urandom_range(0, id_hi));
        tid  = 8'($urandom_range(0, tid_hi));
        tid2 = 8'($urandom_range(0, tid_hi));
        if (r < w_create) begin
          push_request(FN_CREATE, 5'($urandom), tid, 1'($urandom));
          n++;
        end else if (r < w_create + w_session) begin
          // lock, maybe contend or re-enter, then release, mostly by the holder
          push_request(FN_ENTER, id, tid, 1'($urandom));
          if ($urandom_range(0, 1)) begin
            push_request(FN_ENTER, id, $urandom_range(0, 3) == 0 ? tid : tid2, 1'($urandom));
            n++;
          end
          push_request(FN_EXIT, id, $urandom_range(0, 7) == 0 ? tid2 : tid, 1'($urandom));
          n += 2;
        end else if (r < w_create + w_session + w_destroy) begin
          push_request(FN_DESTROY, id, tid, 1'($urandom));
          n++;
        end else begin
          push_request($urandom_range(0, 1) ? FN_ENTER : FN_EXIT, id, tid, 1'($urandom));
          n++;
        end
      end
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (requests_accepted != requests_total) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
